// File: hdl/caching_lock_manager_defines.svh
// ---------------------------------------------------------------------------
// caching lock manager assertion macros
// shared concurrent assertion forms, clocked on clk_i and disabled in reset
// ---------------------------------------------------------------------------
`ifndef CACHING_LOCK_MANAGER_DEFINES_SVH
`define CACHING_LOCK_MANAGER_DEFINES_SVH

// same-cycle implication
`define CLM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define CLM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: hdl/clm_pkg.sv
// ---------------------------------------------------------------------------
// clm_pkg
// types, sizes and codes of the caching lock manager
// ---------------------------------------------------------------------------
`default_nettype none

package clm_pkg;

  // table sizes, all powers of two so index folding is a plain truncation
  localparam int unsigned NUM_LOCKS   = 64;
  localparam int unsigned NUM_CLIENTS = 16;
  localparam int unsigned QUEUE_DEPTH = 8;

  // fixed item field widths
  localparam int unsigned FUNC_W      = 1;
  localparam int unsigned LOCK_FW     = 6;
  localparam int unsigned CLIENT_FW   = 4;
  localparam int unsigned CODE_W      = 2;

  // internal widths
  localparam int unsigned LOCK_W      = $clog2(NUM_LOCKS);
  localparam int unsigned CLIENT_W    = $clog2(NUM_CLIENTS);
  localparam int unsigned SLOT_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [FUNC_W-1:0] {
    FN_ACQUIRE = 1'b0,
    FN_RELEASE = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    PH_LOCKED   = 2'd0,
    PH_REVOKING = 2'd1,
    PH_RETRYING = 2'd2
  } phase_e;

  typedef enum logic [CODE_W-1:0] {
    ST_OK    = 2'd0,
    ST_RETRY = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef enum logic [CODE_W-1:0] {
    NK_NONE   = 2'd0,
    NK_REVOKE = 2'd1,
    NK_RETRY  = 2'd2
  } notify_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef logic [QUEUE_DEPTH-1:0][CLIENT_W-1:0] waiter_row_t;

  typedef struct packed {
    phase_e              phase;
    logic [CLIENT_W-1:0] owner;
    logic [SLOT_W-1:0]   head;
    logic [CNT_W-1:0]    count;
  } lock_entry_t;

  typedef struct packed {
    func_e               func;
    logic [LOCK_W-1:0]   lock;
    logic [CLIENT_W-1:0] client;
  } req_t;

  typedef struct packed {
    logic        known_set;
    logic        ent_we;
    lock_entry_t ent;
    logic        row_we;
    waiter_row_t row;
  } update_t;

  typedef struct packed {
    status_e              status;
    notify_e              kind;
    logic [CLIENT_FW-1:0] client;
    logic [LOCK_FW-1:0]   lock;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/clm_req_if.sv
// ---------------------------------------------------------------------------
// clm_req_if
// request channel: acquire or release of one lock by one client
// ---------------------------------------------------------------------------
`default_nettype none

interface clm_req_if;
  logic                          valid;
  logic                          ready;
  logic [clm_pkg::FUNC_W-1:0]    func;
  logic [clm_pkg::LOCK_FW-1:0]   lock_index;
  logic [clm_pkg::CLIENT_FW-1:0] client_index;

  modport source (output valid, func, lock_index, client_index, input ready);
  modport sink   (input valid, func, lock_index, client_index, output ready);
endinterface

`default_nettype wire

// File: hdl/clm_rsp_if.sv
// ---------------------------------------------------------------------------
// clm_rsp_if
// result channel: reply status and optional callback
// ---------------------------------------------------------------------------
`default_nettype none

interface clm_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [clm_pkg::CODE_W-1:0]    reply_status;
  logic [clm_pkg::CODE_W-1:0]    notify_kind;
  logic [clm_pkg::CLIENT_FW-1:0] notify_client;
  logic [clm_pkg::LOCK_FW-1:0]   notify_lock;

  modport source (output valid, reply_status, notify_kind, notify_client, notify_lock,
                  input ready);
  modport sink   (input valid, reply_status, notify_kind, notify_client, notify_lock,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/clm_decide.sv
// ---------------------------------------------------------------------------
// clm_decide
// lock state transition for one request on a fetched entry and waiter row
// ---------------------------------------------------------------------------
`default_nettype none

module clm_decide (
  input  wire clm_pkg::req_t        req_i,
  input  wire logic                 known_i,
  input  wire clm_pkg::lock_entry_t ent_i,
  input  wire clm_pkg::waiter_row_t row_i,
  output clm_pkg::update_t          upd_o,
  output clm_pkg::result_t          res_o
);

  logic [clm_pkg::CLIENT_W-1:0] front;
  logic [clm_pkg::SLOT_W-1:0]   tail_slot;
  logic                         can_push;
  logic [clm_pkg::CNT_W-1:0]    popped_cnt;
  clm_pkg::notify_e             kind;
  logic [clm_pkg::CLIENT_W-1:0] target;
  clm_pkg::status_e             status;

  assign front     = row_i[ent_i.head];
  assign tail_slot = ent_i.head + ent_i.count[clm_pkg::SLOT_W-1:0];
  assign can_push  = (ent_i.count < clm_pkg::CNT_W'(clm_pkg::QUEUE_DEPTH));

  always_comb begin
    upd_o.known_set = 1'b0;
    upd_o.ent_we    = 1'b0;
    upd_o.ent       = ent_i;
    upd_o.row_we    = 1'b0;
    upd_o.row       = row_i;
    status          = clm_pkg::ST_ERROR;
    kind            = clm_pkg::NK_NONE;
    target          = '0;
    popped_cnt      = ent_i.count;

    if (req_i.func == clm_pkg::FN_ACQUIRE) begin
      if (!known_i) begin
        // first sight of this lock: grant at once
        upd_o.known_set = 1'b1;
        upd_o.ent_we    = 1'b1;
        upd_o.ent.phase = clm_pkg::PH_LOCKED;
        upd_o.ent.owner = req_i.client;
        upd_o.ent.head  = '0;
        upd_o.ent.count = '0;
        status          = clm_pkg::ST_OK;
      end else begin
        case (ent_i.phase) inside
          clm_pkg::PH_LOCKED, clm_pkg::PH_REVOKING: begin
            if (ent_i.owner != req_i.client && can_push) begin
              upd_o.row_we         = 1'b1;
              upd_o.row[tail_slot] = req_i.client;
              upd_o.ent_we         = 1'b1;
              upd_o.ent.count      = ent_i.count + 1'b1;
              status               = clm_pkg::ST_RETRY;
              if (ent_i.phase == clm_pkg::PH_LOCKED) begin
                upd_o.ent.phase = clm_pkg::PH_REVOKING;
                kind            = clm_pkg::NK_REVOKE;
                target          = ent_i.owner;
              end
            end
          end
          clm_pkg::PH_RETRYING: begin
            if (ent_i.count == '0 || front == req_i.client) begin
              if (ent_i.count != '0) begin
                popped_cnt     = ent_i.count - 1'b1;
                upd_o.ent.head = ent_i.head + 1'b1;
              end
              upd_o.ent_we    = 1'b1;
              upd_o.ent.count = popped_cnt;
              upd_o.ent.owner = req_i.client;
              upd_o.ent.phase = clm_pkg::PH_LOCKED;
              status          = clm_pkg::ST_OK;
              // others still queued: start taking it back straight away
              if (popped_cnt != '0) begin
                upd_o.ent.phase = clm_pkg::PH_REVOKING;
                kind            = clm_pkg::NK_REVOKE;
                target          = req_i.client;
              end
            end else if (can_push) begin
              upd_o.row_we         = 1'b1;
              upd_o.row[tail_slot] = req_i.client;
              upd_o.ent_we         = 1'b1;
              upd_o.ent.count      = ent_i.count + 1'b1;
              status               = clm_pkg::ST_RETRY;
            end
          end
          default: begin
            status = clm_pkg::ST_ERROR;
          end
        endcase
      end
    end else begin
      if (known_i && ent_i.phase == clm_pkg::PH_REVOKING && ent_i.owner == req_i.client) begin
        upd_o.ent_we    = 1'b1;
        upd_o.ent.phase = clm_pkg::PH_RETRYING;
        status          = clm_pkg::ST_OK;
        if (ent_i.count != '0) begin
          kind   = clm_pkg::NK_RETRY;
          target = front;
        end
      end
    end

    res_o.status = status;
    res_o.kind   = kind;
    res_o.client = (kind != clm_pkg::NK_NONE) ? clm_pkg::CLIENT_FW'(target) : '0;
    res_o.lock   = (kind != clm_pkg::NK_NONE) ? clm_pkg::LOCK_FW'(req_i.lock) : '0;
  end

endmodule

`default_nettype wire

// File: hdl/caching_lock_manager.sv
// ---------------------------------------------------------------------------
// caching_lock_manager
// lock table with revoke and retry callbacks, one request at a time
// ---------------------------------------------------------------------------
// A request is accepted, then executed: in the accept cycle the lock's entry
// (phase, owner, queue head and count) and its whole row of waiting clients
// are read from two synchronous memories; in the next cycle the new state is
// decided, written back and the reply placed in the result register. The
// next request is taken in the cycle after that. The result register holds
// one reply, so a new request is accepted while the previous reply still
// waits; the exec cycle stretches only when a second reply would overwrite
// an untaken one. The known-lock bits live in flip-flops cleared by reset,
// so there is no clearing pass and the block takes requests from the first
// cycle after reset. Lock and client indices are folded by truncation.
// ---------------------------------------------------------------------------
`default_nettype none

module caching_lock_manager (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  clm_req_if.sink   req,
  clm_rsp_if.source rsp
);

  // control
  clm_pkg::state_e              state_q, state_d;
  logic                         accept;
  logic                         exec_fire;
  logic                         rsp_valid_q, rsp_valid_d;

  // captured request, payload only
  clm_pkg::req_t                req_q;

  // known bits, one per lock
  logic [clm_pkg::NUM_LOCKS-1:0] known_q;

  // lock entry and waiter row memories with registered read data
  clm_pkg::lock_entry_t         ent_mem [clm_pkg::NUM_LOCKS];
  clm_pkg::waiter_row_t         row_mem [clm_pkg::NUM_LOCKS];
  clm_pkg::lock_entry_t         ent_rd_q;
  clm_pkg::waiter_row_t         row_rd_q;
  logic [clm_pkg::LOCK_W-1:0]   rd_addr;

  // decision
  clm_pkg::update_t             upd;
  clm_pkg::result_t             res;
  clm_pkg::result_t             res_q;

  // fold the request's lock index into the table
  assign rd_addr = req.lock_index[clm_pkg::LOCK_W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      clm_pkg::S_IDLE: if (req.valid) state_d = clm_pkg::S_EXEC;
      clm_pkg::S_EXEC: if (!rsp_valid_q || rsp.ready) state_d = clm_pkg::S_IDLE;
      default:         state_d = clm_pkg::S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    req.ready = 1'b0;
    exec_fire = 1'b0;
    unique case (state_q)
      clm_pkg::S_IDLE: req.ready = 1'b1;
      clm_pkg::S_EXEC: exec_fire = !rsp_valid_q || rsp.ready;
      default: begin
        req.ready = 1'b0;
        exec_fire = 1'b0;
      end
    endcase
  end

  assign accept = req.valid && req.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.func   <= clm_pkg::func_e'(req.func);
      req_q.lock   <= rd_addr;
      req_q.client <= req.client_index[clm_pkg::CLIENT_W-1:0];
    end
  end

  // entry memory: read on accept, write back on exec
  always_ff @(posedge clk_i) begin
    if (exec_fire && upd.ent_we) begin
      ent_mem[req_q.lock] <= upd.ent;
    end
    if (accept) begin
      ent_rd_q <= ent_mem[rd_addr];
    end
  end

  // waiter row memory: whole row read, one slot changed per write
  always_ff @(posedge clk_i) begin
    if (exec_fire && upd.row_we) begin
      row_mem[req_q.lock] <= upd.row;
    end
    if (accept) begin
      row_rd_q <= row_mem[rd_addr];
    end
  end

  // known bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q <= '0;
    end else if (exec_fire && upd.known_set) begin
      known_q[req_q.lock] <= 1'b1;
    end
  end

  clm_decide u_decide (
    .req_i   (req_q),
    .known_i (known_q[req_q.lock]),
    .ent_i   (ent_rd_q),
    .row_i   (row_rd_q),
    .upd_o   (upd),
    .res_o   (res)
  );

  // result register
  assign rsp_valid_d = exec_fire || (rsp_valid_q && !rsp.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      res_q <= res;
    end
  end

  assign rsp.valid         = rsp_valid_q;
  assign rsp.reply_status  = res_q.status;
  assign rsp.notify_kind   = res_q.kind;
  assign rsp.notify_client = res_q.client;
  assign rsp.notify_lock   = res_q.lock;

endmodule

`default_nettype wire

// File: hdl/clm_checker.sv
// ---------------------------------------------------------------------------
// clm_checker
// port-level checks of the caching lock manager, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "caching_lock_manager_defines.svh"

module clm_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          req_valid_i,
  input wire logic                          req_ready_i,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic [clm_pkg::CODE_W-1:0]    reply_status_i,
  input wire logic [clm_pkg::CODE_W-1:0]    notify_kind_i,
  input wire logic [clm_pkg::CLIENT_FW-1:0] notify_client_i,
  input wire logic [clm_pkg::LOCK_FW-1:0]   notify_lock_i
);

  // an untaken item stays put
  `CLM_ASSERT_NXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i && $stable(reply_status_i) && $stable(notify_kind_i) && $stable(notify_client_i) && $stable(notify_lock_i))

  // one request in flight: no accept in the cycle after an accept
  `CLM_ASSERT_NXT(a_one_in_flight, req_valid_i && req_ready_i, !req_ready_i)

  // no callback means zeroed callback fields
  `CLM_ASSERT_IMP(a_quiet_notify, rsp_valid_i && notify_kind_i == clm_pkg::NK_NONE, notify_client_i == '0 && notify_lock_i == '0)

  // an error never carries a callback
  `CLM_ASSERT_IMP(a_error_silent, rsp_valid_i && reply_status_i == clm_pkg::ST_ERROR, notify_kind_i == clm_pkg::NK_NONE)

  // a retry callback only follows a good release
  `CLM_ASSERT_IMP(a_retry_on_ok, rsp_valid_i && notify_kind_i == clm_pkg::NK_RETRY, reply_status_i == clm_pkg::ST_OK)

endmodule

bind caching_lock_manager clm_checker u_clm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req.valid),
  .req_ready_i     (req.ready),
  .rsp_valid_i     (rsp.valid),
  .rsp_ready_i     (rsp.ready),
  .reply_status_i  (rsp.reply_status),
  .notify_kind_i   (rsp.notify_kind),
  .notify_client_i (rsp.notify_client),
  .notify_lock_i   (rsp.notify_lock)
);

`default_nettype wire
